[hdl/grid_dda_raycaster_macros.svh]
// Assertion macros used by the ray caster top level.
`ifndef GRID_DDA_RAYCASTER_MACROS_SVH
`define GRID_DDA_RAYCASTER_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define GDR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ray caster check failed");

// Check that a condition implies a consequence in the next cycle.
`define GDR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ray caster check failed");

`endif

[hdl/gdr_pkg.sv]
// Package with the fixed widths and constants of the ray caster.
package gdr_pkg;
  localparam int DELTA_W = 33;
  localparam int SD_W = 48;
  localparam int CELL_W = 10;
  localparam int MAG_W = 18;
  localparam logic [DELTA_W-1:0] DELTA_ZERO = 33'h1FFFFFFFF;
  localparam logic [23:0] DIST_MIN = 24'd7;
  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST = 1'b1;
endpackage

[hdl/grid_dda_raycaster.sv]
// Top level of the DDA ray caster over a one-bit wall map.
// A cast runs the divider in DIV, one multiply in MUL, the grid steps in WALK
// (at most MAX_STEPS) and loads the result in DONE.
// A new request is taken the cycle after the result loads; DONE holds the
// result back while the output stalls. A map write is stored when accepted.
// After reset a clearing pass opens all MAP_COLS*MAP_ROWS cells; no request is taken until it ends.
module grid_dda_raycaster #(
  parameter int MAP_COLS = 32,
  parameter int MAP_ROWS = 32,
  parameter int MAX_STEPS = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                kind,
  input  logic [4:0]          cell_col,
  input  logic [4:0]          cell_row,
  input  logic                cell_is_wall,
  input  logic [20:0]         pos_x,
  input  logic [20:0]         pos_y,
  input  logic signed [17:0]  dir_x,
  input  logic signed [17:0]  dir_y,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [23:0]         distance,
  output logic                hit_side
);
`include "grid_dda_raycaster_macros.svh"

  localparam int DEPTH = MAP_COLS * MAP_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int DW = gdr_pkg::DELTA_W;
  localparam int SW = gdr_pkg::SD_W;
  localparam int CW = gdr_pkg::CELL_W;
  localparam int MW = gdr_pkg::MAG_W;

  typedef enum logic [2:0] {IDLE, DIV, MUL, WALK, DONE} state_t;

  state_t state;
  logic mem [DEPTH];
  logic rd_wall;
  logic clr_busy;
  logic [ADDR_W-1:0] clr_addr;

  logic [MW-1:0] mag_x, mag_y;
  logic [MW-1:0] rem_x, rem_y;
  logic [DW-1:0] q_x, q_y;
  logic [5:0] div_cnt;
  logic neg_x, neg_y;
  logic [15:0] frac_x, frac_y;
  logic signed [CW-1:0] cx, cy;
  logic [DW-1:0] dx, dy;
  logic [SW-1:0] sdx, sdy;
  logic [STEP_W-1:0] steps;
  logic chk, oob, side;

  logic accept, do_write, wr_in_map;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [MW:0] rs_x, rs_y;
  logic ge_x, ge_y;
  logic [DW-1:0] delta_x, delta_y;
  logic [16:0] f_x, f_y;
  logic [DW+16:0] prod_x, prod_y;
  logic take_x, stop;
  logic signed [CW-1:0] cx_next, cy_next;
  logic [SW-1:0] sdx_next, sdy_next, last_dist;
  logic oob_next;

  assign in_ready = (state == IDLE) && !clr_busy;
  assign accept = in_valid && in_ready;
  assign wr_in_map = ({27'b0, cell_col} < MAP_COLS) && ({27'b0, cell_row} < MAP_ROWS);
  assign do_write = accept && (kind == gdr_pkg::KIND_WRITE) && wr_in_map;
  assign wr_addr = ADDR_W'(ADDR_W'(cell_row) * ADDR_W'(MAP_COLS) + ADDR_W'(cell_col));

  assign rs_x = {rem_x, div_cnt == 6'd32};
  assign rs_y = {rem_y, div_cnt == 6'd32};
  assign ge_x = rs_x >= {1'b0, mag_x};
  assign ge_y = rs_y >= {1'b0, mag_y};

  assign delta_x = (mag_x == '0) ? gdr_pkg::DELTA_ZERO : q_x;
  assign delta_y = (mag_y == '0) ? gdr_pkg::DELTA_ZERO : q_y;
  assign f_x = neg_x ? {1'b0, frac_x} : 17'h10000 - {1'b0, frac_x};
  assign f_y = neg_y ? {1'b0, frac_y} : 17'h10000 - {1'b0, frac_y};
  assign prod_x = f_x * delta_x;
  assign prod_y = f_y * delta_y;

  assign take_x = sdx < sdy;
  assign stop = chk && (oob || rd_wall || (steps == STEP_W'(MAX_STEPS)));

  always_comb begin
    cx_next = cx;
    cy_next = cy;
    sdx_next = sdx;
    sdy_next = sdy;
    if (take_x) begin
      cx_next = neg_x ? cx - CW'(1) : cx + CW'(1);
      sdx_next = sdx + SW'(dx);
    end else begin
      cy_next = neg_y ? cy - CW'(1) : cy + CW'(1);
      sdy_next = sdy + SW'(dy);
    end
    oob_next = cx_next[CW-1] || cy_next[CW-1] || (32'(cx_next) >= MAP_COLS) ||
               (32'(cy_next) >= MAP_ROWS);
    rd_addr = ADDR_W'(ADDR_W'(cy_next[CW-2:0]) * ADDR_W'(MAP_COLS) +
                      ADDR_W'(cx_next[CW-2:0]));
    last_dist = side ? sdy - SW'(dy) : sdx - SW'(dx);
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= 1'b0;
    end else if (do_write) begin
      mem[wr_addr] <= cell_is_wall;
    end
    rd_wall <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept && (kind == gdr_pkg::KIND_CAST)) begin
            mag_x <= dir_x[17] ? MW'(-dir_x) : MW'(dir_x);
            mag_y <= dir_y[17] ? MW'(-dir_y) : MW'(dir_y);
            neg_x <= dir_x[17];
            neg_y <= dir_y[17];
            frac_x <= pos_x[15:0];
            frac_y <= pos_y[15:0];
            cx <= CW'(pos_x[20:16]);
            cy <= CW'(pos_y[20:16]);
            rem_x <= '0;
            rem_y <= '0;
            div_cnt <= 6'd32;
            state <= DIV;
          end
        end
        DIV: begin
          rem_x <= ge_x ? MW'(rs_x - {1'b0, mag_x}) : MW'(rs_x);
          rem_y <= ge_y ? MW'(rs_y - {1'b0, mag_y}) : MW'(rs_y);
          q_x <= {q_x[DW-2:0], ge_x};
          q_y <= {q_y[DW-2:0], ge_y};
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == 6'd0) begin
            state <= MUL;
          end
        end
        MUL: begin
          dx <= delta_x;
          dy <= delta_y;
          sdx <= SW'(prod_x[DW+16:16]);
          sdy <= SW'(prod_y[DW+16:16]);
          steps <= '0;
          chk <= 1'b0;
          state <= WALK;
        end
        WALK: begin
          if (stop) begin
            state <= DONE;
          end else begin
            cx <= cx_next;
            cy <= cy_next;
            sdx <= sdx_next;
            sdy <= sdy_next;
            side <= !take_x;
            oob <= oob_next;
            steps <= steps + STEP_W'(1);
            chk <= 1'b1;
          end
        end
        DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            hit_side <= side;
            if (last_dist < SW'(gdr_pkg::DIST_MIN)) begin
              distance <= gdr_pkg::DIST_MIN;
            end else if (last_dist > SW'(gdr_pkg::DIST_MAX)) begin
              distance <= gdr_pkg::DIST_MAX;
            end else begin
              distance <= last_dist[23:0];
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `GDR_ASSERT_SAME(a_no_accept_clear, clr_busy, !in_ready)
  `GDR_ASSERT_SAME(a_steps_bound, state == WALK, steps <= STEP_W'(MAX_STEPS))
  `GDR_ASSERT_NEXT(a_write_idle, accept && (kind == gdr_pkg::KIND_WRITE), state == IDLE)
  `GDR_ASSERT_NEXT(a_done_out, (state == DONE) && (!out_valid || out_ready), out_valid)

endmodule
